@@ src/assert_macros.svh @@
// Assertion helpers for the 1-Wire master checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OWM_ASSERT_IMP(lbl, ck, rn, ant, con) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |-> (con)) \
        else $error("one-wire master check failed");

// next-cycle implication
`define OWM_ASSERT_NXT(lbl, ck, rn, ant, con) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ant) |=> (con)) \
        else $error("one-wire master check failed");

`endif

@@ src/owm_pkg.sv @@
`default_nettype none

package owm_pkg;

    localparam int COUNTER_BITS_DEF    = 10;
    localparam int SHORT_LOW_TICKS_DEF = 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [9:0] RESET_LOW_DEF     = 10'd500;
    localparam logic [7:0] PRESENCE_WAIT_DEF = 8'd65;
    localparam logic [9:0] RESET_TAIL_DEF    = 10'd480;
    localparam logic [6:0] ZERO_LOW_DEF      = 7'd63;
    localparam logic [6:0] WRITE_SLOT_DEF    = 7'd64;
    localparam logic [6:0] WRITE_GAP_DEF     = 7'd5;
    localparam logic [3:0] READ_SAMPLE_DEF   = 4'd2;
    localparam logic [6:0] READ_SLOT_DEF     = 7'd37;

    localparam logic [6:0] MIN_SLOT_TICKS = 7'd3;
    localparam logic [6:0] MIN_ZERO_LOW   = 7'd2;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_RESET = 2'd1,
        MODE_WRITE = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW     = 3'd0,
        CFG_PRESENCE_WAIT = 3'd1,
        CFG_RESET_TAIL    = 3'd2,
        CFG_ZERO_LOW      = 3'd3,
        CFG_WRITE_SLOT    = 3'd4,
        CFG_WRITE_GAP     = 3'd5,
        CFG_READ_SAMPLE   = 3'd6,
        CFG_READ_SLOT     = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_RST_LOW    = 3'd1,
        PH_RST_WAIT   = 3'd2,
        PH_RST_SAMPLE = 3'd3,
        PH_RST_TAIL   = 3'd4,
        PH_WR_BIT     = 3'd5,
        PH_WR_GAP     = 3'd6,
        PH_RD_BIT     = 3'd7
    } phase_t;

    // one queued tick: command, write byte and bus sample
    typedef struct packed {
        mode_t      cmd;
        logic [7:0] wdata;
        logic       line;
    } tick_word_t;

endpackage

`default_nettype wire

@@ src/owm_front.sv @@
`default_nettype none

module owm_front
    import owm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] mode,
    input  wire logic [7:0] write_data,
    input  wire logic       line_level,
    output logic            q_valid,
    output tick_word_t      q_word,
    input  wire logic       q_pop
);

    tick_word_t          queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    tick_word_t          word_in;

    assign in_stall = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_word   = queue_reg[rptr_reg];

    always_comb
    begin
        word_in.cmd   = mode_t'(mode);
        word_in.wdata = write_data;
        word_in.line  = line_level;
        wptr_next  = push  ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = q_pop ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wptr_reg] <= word_in;
        end
    end

endmodule

`default_nettype wire

@@ src/owm_engine.sv @@
`default_nettype none

module owm_engine
    import owm_pkg::*;
#(
    parameter int COUNTER_BITS    = COUNTER_BITS_DEF,
    parameter int SHORT_LOW_TICKS = SHORT_LOW_TICKS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  q_valid,
    input  wire tick_word_t            q_word,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       drive_low,
    output logic                       busy_res,
    output logic                       done_res,
    output logic                       presence,
    output logic [7:0]                 read_data,
    output logic                       rejected
);

    localparam int CB = COUNTER_BITS;
    localparam int EW = (COUNTER_BITS > CFG_DATA_W) ? COUNTER_BITS : CFG_DATA_W;

    // timing registers
    logic [9:0] rst_low_reg, rst_tail_reg;
    logic [7:0] pres_wait_reg;
    logic [6:0] zero_low_reg, wr_slot_reg, wr_gap_reg, rd_slot_reg;
    logic [3:0] rd_samp_reg;

    // bus state
    phase_t       phase_reg, phase_next;
    logic [CB-1:0] tick_reg, tick_next;
    logic [2:0]   bit_reg, bit_next;
    logic [7:0]   shift_reg, shift_next;
    logic         pres_reg, pres_next;

    // result word
    logic       out_valid_reg;
    logic       drive_reg, drive_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [7:0] rdata_reg, rdata_next;
    logic       rej_reg, rej_next;

    logic          advance;
    logic          bit_end;
    logic          wr_lsb;
    logic [CB-1:0] rst_low_len, pres_wait_len, rst_tail_len;
    logic [EW-1:0] rst_low_ext, rst_tail_ext;
    logic [6:0]    wr_slot, wr_low, rd_slot, rd_low, rd_samp, zero_low, rd_samp_lo;
    logic [CB-1:0] tick_inc;

    assign advance   = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop     = advance;
    assign out_valid = out_valid_reg;
    assign drive_low = drive_reg;
    assign busy_res  = busy_reg;
    assign done_res  = done_reg;
    assign presence  = pres_reg;
    assign read_data = rdata_reg;
    assign rejected  = rej_reg;

    // slot geometry, clamped as the bus timing requires
    always_comb
    begin
        rst_low_ext   = EW'(rst_low_reg);
        rst_tail_ext  = EW'(rst_tail_reg);
        rst_low_len   = (rst_low_ext[CB-1:0] == '0) ? CB'(1) : rst_low_ext[CB-1:0];
        rst_tail_len  = rst_tail_ext[CB-1:0];
        pres_wait_len = (pres_wait_reg == '0) ? CB'(1) : CB'(pres_wait_reg);

        // a write starting this tick takes its first bit straight from the word
        wr_lsb   = (phase_reg == PH_IDLE && q_word.cmd == MODE_WRITE) ? q_word.wdata[0]
                                                                      : shift_reg[0];
        wr_slot  = (wr_slot_reg < MIN_SLOT_TICKS) ? MIN_SLOT_TICKS : wr_slot_reg;
        zero_low = (zero_low_reg < MIN_ZERO_LOW) ? MIN_ZERO_LOW : zero_low_reg;
        wr_low   = wr_lsb ? 7'(SHORT_LOW_TICKS) : zero_low;
        if (wr_low > wr_slot - 7'd1)
        begin
            wr_low = wr_slot - 7'd1;
        end

        rd_slot = (rd_slot_reg < MIN_SLOT_TICKS) ? MIN_SLOT_TICKS : rd_slot_reg;
        rd_low  = 7'(SHORT_LOW_TICKS);
        if (rd_low > rd_slot - 7'd1)
        begin
            rd_low = rd_slot - 7'd1;
        end
        rd_samp_lo = (7'(rd_samp_reg) < rd_low) ? rd_low : 7'(rd_samp_reg);
        rd_samp    = (rd_samp_lo > rd_slot - 7'd1) ? rd_slot - 7'd1 : rd_samp_lo;
    end

    // one bus tick
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        pres_next  = pres_reg;
        drive_next = 1'b0;
        busy_next  = 1'b0;
        done_next  = 1'b0;
        rdata_next = 8'd0;
        rej_next   = 1'b0;
        bit_end    = 1'b0;
        tick_inc   = '0;

        if (q_word.cmd != MODE_NONE)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rej_next = 1'b1;
            end
            else
            begin
                tick_next = '0;
                bit_next  = '0;
                case (q_word.cmd)
                    MODE_RESET:
                    begin
                        phase_next = PH_RST_LOW;
                        tick_next  = rst_low_len;
                    end
                    MODE_WRITE:
                    begin
                        phase_next = PH_WR_BIT;
                        shift_next = q_word.wdata;
                    end
                    default:
                    begin
                        phase_next = PH_RD_BIT;
                        shift_next = 8'd0;
                    end
                endcase
            end
        end

        if (phase_next != PH_IDLE)
        begin
            busy_next = 1'b1;
            tick_inc  = tick_next + 1'b1;
            case (phase_next)
                PH_RST_LOW:
                begin
                    drive_next = 1'b1;
                    tick_next  = tick_next - 1'b1;
                    if (tick_next == '0)
                    begin
                        phase_next = PH_RST_WAIT;
                        tick_next  = pres_wait_len;
                    end
                end
                PH_RST_WAIT:
                begin
                    tick_next = tick_next - 1'b1;
                    if (tick_next == '0)
                    begin
                        phase_next = PH_RST_SAMPLE;
                    end
                end
                PH_RST_SAMPLE:
                begin
                    pres_next = !q_word.line;
                    tick_next = rst_tail_len;
                    if (rst_tail_len == '0)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_RST_TAIL;
                    end
                end
                PH_RST_TAIL:
                begin
                    tick_next = tick_next - 1'b1;
                    if (tick_next == '0)
                    begin
                        done_next = 1'b1;
                    end
                end
                PH_WR_BIT:
                begin
                    drive_next = (tick_next < CB'(wr_low));
                    tick_next  = tick_inc;
                    if (tick_inc >= CB'(wr_slot))
                    begin
                        tick_next = '0;
                        if (wr_gap_reg == '0)
                        begin
                            bit_end = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_WR_GAP;
                        end
                    end
                end
                PH_WR_GAP:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= CB'(wr_gap_reg))
                    begin
                        tick_next = '0;
                        bit_end   = 1'b1;
                    end
                end
                PH_RD_BIT:
                begin
                    drive_next = (tick_next < CB'(rd_low));
                    if (tick_next == CB'(rd_samp))
                    begin
                        shift_next = {q_word.line, shift_next[7:1]};
                    end
                    tick_next = tick_inc;
                    if (tick_inc >= CB'(rd_slot))
                    begin
                        tick_next = '0;
                        if (bit_next == 3'd7)
                        begin
                            done_next  = 1'b1;
                            rdata_next = shift_next;
                        end
                        else
                        begin
                            bit_next = bit_next + 3'd1;
                        end
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase

            if (bit_end)
            begin
                shift_next = {1'b0, shift_next[7:1]};
                if (bit_next == 3'd7)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    bit_next   = bit_next + 3'd1;
                    phase_next = PH_WR_BIT;
                end
            end

            if (done_next)
            begin
                phase_next = PH_IDLE;
                tick_next  = '0;
                bit_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rst_low_reg   <= RESET_LOW_DEF;
            pres_wait_reg <= PRESENCE_WAIT_DEF;
            rst_tail_reg  <= RESET_TAIL_DEF;
            zero_low_reg  <= ZERO_LOW_DEF;
            wr_slot_reg   <= WRITE_SLOT_DEF;
            wr_gap_reg    <= WRITE_GAP_DEF;
            rd_samp_reg   <= READ_SAMPLE_DEF;
            rd_slot_reg   <= READ_SLOT_DEF;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_RESET_LOW:     rst_low_reg   <= cfg_data[9:0];
                CFG_PRESENCE_WAIT: pres_wait_reg <= cfg_data[7:0];
                CFG_RESET_TAIL:    rst_tail_reg  <= cfg_data[9:0];
                CFG_ZERO_LOW:      zero_low_reg  <= cfg_data[6:0];
                CFG_WRITE_SLOT:    wr_slot_reg   <= cfg_data[6:0];
                CFG_WRITE_GAP:     wr_gap_reg    <= cfg_data[6:0];
                CFG_READ_SAMPLE:   rd_samp_reg   <= cfg_data[3:0];
                CFG_READ_SLOT:     rd_slot_reg   <= cfg_data[6:0];
                default:           rd_slot_reg   <= rd_slot_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bit_reg       <= '0;
            shift_reg     <= '0;
            pres_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg <= phase_next;
                tick_reg  <= tick_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                pres_reg  <= pres_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // presence is carried by pres_reg, which only moves with the result word
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_reg <= drive_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            rdata_reg <= rdata_next;
            rej_reg   <= rej_next;
        end
    end

endmodule

`default_nettype wire

@@ src/one_wire_bus_master.sv @@
// A word accepted into the queue is popped by the engine into the result register, which
// drives the outputs. Throughput: one word per cycle unless out_stall holds the result;
// the bus tick engine steps once per word.
// A four-entry queue sits in front of the engine, one result register behind it.
// Reset (rst_n low, asynchronous) empties the queue and result register, sets the
// bus idle with presence 0 and loads the timing registers with their defaults.
`default_nettype none

module one_wire_bus_master
    import owm_pkg::*;
#(
    parameter int COUNTER_BITS    = COUNTER_BITS_DEF,
    parameter int SHORT_LOW_TICKS = SHORT_LOW_TICKS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            mode,
    input  wire logic [7:0]            write_data,
    input  wire logic                  line_level,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       drive_low,
    output logic                       busy_res,
    output logic                       done_res,
    output logic                       presence,
    output logic [7:0]                 read_data,
    output logic                       rejected
);

    logic       q_valid;
    logic       q_pop;
    tick_word_t q_word;

    owm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .write_data (write_data),
        .line_level (line_level),
        .q_valid    (q_valid),
        .q_word     (q_word),
        .q_pop      (q_pop)
    );

    owm_engine #(
        .COUNTER_BITS    (COUNTER_BITS),
        .SHORT_LOW_TICKS (SHORT_LOW_TICKS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .drive_low (drive_low),
        .busy_res  (busy_res),
        .done_res  (done_res),
        .presence  (presence),
        .read_data (read_data),
        .rejected  (rejected)
    );

endmodule

`default_nettype wire

@@ src/owm_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module owm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       drive_low,
    input wire logic       busy_res,
    input wire logic       done_res,
    input wire logic [7:0] read_data
);

    // the bus is only pulled low inside an operation
    `OWM_ASSERT_IMP(a_drive_busy, clk, rst_n, out_valid && drive_low, busy_res)

    // completion word always belongs to an operation
    `OWM_ASSERT_IMP(a_done_busy, clk, rst_n, out_valid && done_res, busy_res)

    // read byte shows only on the completing word
    `OWM_ASSERT_IMP(a_rdata_done, clk, rst_n, out_valid && (read_data != 8'd0), done_res)

    // held result word stays put
    `OWM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(drive_low) && $stable(done_res) && $stable(read_data))

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive_low (drive_low),
    .busy_res  (busy_res),
    .done_res  (done_res),
    .read_data (read_data)
);

`default_nettype wire
